// ----- rtl/hlcm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlcm_pkg
// shared widths and payload types for the hough line cluster merge block
// ----------------------------------------------------------------------------
package hlcm_pkg;
	localparam int MaxLines = 64;
	localparam int IdxW     = $clog2(MaxLines);
	localparam int CntW     = $clog2(MaxLines + 1);
	localparam int SumW     = 16 + CntW;

	localparam logic [1:0] RegRhoBracket   = 2'd0;
	localparam logic [1:0] RegThetaBracket = 2'd1;

	typedef struct packed {
		logic signed [15:0] line_rho;
		logic [15:0]        line_theta;
		logic               last_line;
	} line_item_t;

	typedef struct packed {
		logic signed [15:0] mean_rho;
		logic [15:0]        mean_theta;
		logic [6:0]         member_count;
		logic               lines_dropped;
		logic               last_cluster;
	} cluster_item_t;

	// divider request from the cluster sequencer
	typedef struct packed {
		logic                   start;
		logic signed [SumW-1:0] rho_sum;
		logic [SumW-1:0]        theta_sum;
		logic [CntW-1:0]        members;
	} div_req_t;
endpackage

// ----- rtl/hlcm_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlcm_line_if / hlcm_cluster_if
// valid/ready channels for line items and cluster items
// ----------------------------------------------------------------------------
interface hlcm_line_if import hlcm_pkg::*; ();
	logic       valid;
	logic       ready;
	line_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface hlcm_cluster_if import hlcm_pkg::*; ();
	logic          valid;
	logic          ready;
	cluster_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/hlcm_mean_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlcm_mean_div
// restoring divider for rounded cluster means, one quotient bit per cycle
// ----------------------------------------------------------------------------
module hlcm_mean_div import hlcm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  div_req_t           req,
	output logic               done,
	output logic signed [15:0] mean_rho,
	output logic [15:0]        mean_theta
);
	localparam int NumW = SumW + 2;
	localparam int DenW = CntW + 1;
	localparam int StepW = $clog2(NumW + 1);

	logic            busy_q;
	logic [StepW-1:0] step_q;
	logic            neg_q;
	logic [NumW-1:0] rn_q, tn_q;
	logic [NumW-1:0] rr_q, tr_q;
	logic [DenW-1:0] den_q;
	logic [NumW:0]   rr_sh, tr_sh;
	logic [NumW:0]   den_x;
	logic signed [NumW:0] rnum;
	logic [NumW-1:0] rmag;

	// numerator 2*sum + n; floor for negatives via (|num| + den - 1) / den
	always_comb begin
		rnum = $signed({req.rho_sum[SumW-1], req.rho_sum[SumW-1], req.rho_sum, 1'b0}) +
		       $signed((NumW+1)'(req.members));
		if (rnum < 0)
			rmag = NumW'(-rnum) + NumW'({req.members, 1'b0}) - NumW'(1);
		else
			rmag = NumW'(rnum);
		den_x = (NumW+1)'(den_q);
		rr_sh = {rr_q, rn_q[NumW-1]};
		tr_sh = {tr_q, tn_q[NumW-1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			step_q <= '0;
		end else begin
			done <= busy_q && !req.start && (step_q == StepW'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= StepW'(NumW);
				neg_q  <= rnum < 0;
				rn_q   <= rmag;
				tn_q   <= NumW'({req.theta_sum, 1'b0}) + NumW'(req.members);
				den_q  <= {req.members, 1'b0};
				rr_q   <= '0;
				tr_q   <= '0;
			end else if (busy_q) begin
				if (rr_sh >= den_x) begin
					rr_q <= NumW'(rr_sh - den_x);
					rn_q <= {rn_q[NumW-2:0], 1'b1};
				end else begin
					rr_q <= NumW'(rr_sh);
					rn_q <= {rn_q[NumW-2:0], 1'b0};
				end
				if (tr_sh >= den_x) begin
					tr_q <= NumW'(tr_sh - den_x);
					tn_q <= {tn_q[NumW-2:0], 1'b1};
				end else begin
					tr_q <= NumW'(tr_sh);
					tn_q <= {tn_q[NumW-2:0], 1'b0};
				end
				step_q <= step_q - StepW'(1);
				if (step_q == StepW'(1))
					busy_q <= 1'b0;
			end
		end
	end

	assign mean_rho   = neg_q ? -$signed(rn_q[15:0]) : $signed(rn_q[15:0]);
	assign mean_theta = tn_q[15:0];
endmodule

// ----- rtl/hough_line_cluster_merge_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hough_line_cluster_merge_core
// single-linkage clustering of hough lines held in on-chip memory
// ----------------------------------------------------------------------------
// loading: one line item per cycle into the line memory, ready only while loading
// clustering: each (queued line, candidate) pair passes through a read state
//   and a compare state, since the store has a single read port, and each
//   cluster then waits for its mean division
// reset: all control state cleared at once, line memory and queue undefined
// ----------------------------------------------------------------------------
module hough_line_cluster_merge_core import hlcm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	hlcm_line_if.sink      line_in,
	hlcm_cluster_if.source cluster_out
);
	typedef enum logic [3:0] {
		ST_LOAD, ST_SEED, ST_POP, ST_CUR, ST_SCAN, ST_CMP, ST_DIV, ST_WAIT, ST_OUT
	} state_t;

	state_t state_q;

	logic [14:0] rho_br_q;
	logic [15:0] theta_br_q;

	// line store and work queue, single port synchronous memories
	logic [31:0]     line_mem [MaxLines];
	logic [IdxW-1:0] queue_mem [MaxLines];
	logic [31:0]     line_rd_q;
	logic [IdxW-1:0] queue_rd_q;
	logic [MaxLines-1:0] assigned_q;

	logic [CntW-1:0] count_q;
	logic            overflow_q;
	logic [CntW-1:0] seed_q, k_q, head_q, tail_q;
	logic signed [SumW-1:0] rho_sum_q;
	logic [SumW-1:0] theta_sum_q;
	logic signed [15:0] cur_rho_q;
	logic [15:0]        cur_theta_q;
	logic            last_seed_q;
	cluster_item_t   out_q;
	logic            out_valid_q;
	div_req_t        div_req;
	logic            div_done;
	logic signed [15:0] div_rho;
	logic [15:0]     div_theta;

	logic signed [16:0] dr, dr_abs;
	logic signed [16:0] dt, dt_abs;
	logic            nbr;
	logic [CntW-1:0] next_seed;
	logic            any_open;

	// neighbour test of the current line against the candidate just read
	always_comb begin
		dr = 17'(cur_rho_q) - 17'($signed(line_rd_q[31:16]));
		dt = $signed({1'b0, cur_theta_q}) - $signed({1'b0, line_rd_q[15:0]});
		dr_abs = dr[16] ? -dr : dr;
		dt_abs = dt[16] ? -dt : dt;
		nbr = (dr_abs <= $signed({2'b0, rho_br_q})) &&
		      (dt_abs <= $signed({1'b0, theta_br_q}));
	end

	// any stored line of the set still without a cluster
	always_comb begin
		any_open = 1'b0;
		for (int i = 0; i < MaxLines; i++)
			if (i < int'(count_q) && !assigned_q[i])
				any_open = 1'b1;
	end

	// the output register holds the last cluster item while the next set loads
	assign line_in.ready = (state_q == ST_LOAD);
	assign cluster_out.valid = out_valid_q;
	assign cluster_out.data  = out_q;

	assign div_req.start     = (state_q == ST_DIV);
	assign div_req.rho_sum   = rho_sum_q;
	assign div_req.theta_sum = theta_sum_q;
	assign div_req.members   = tail_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rho_br_q   <= 15'd80;
			theta_br_q <= 16'd2048;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegRhoBracket[0:0]:   rho_br_q   <= cfg_wdata[14:0];
				RegThetaBracket[0:0]: theta_br_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// memory ports: one access per cycle each
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && line_in.valid && line_in.ready &&
		    count_q != CntW'(MaxLines))
			line_mem[count_q[IdxW-1:0]] <= {line_in.data.line_rho, line_in.data.line_theta};
		case (state_q)
			ST_SEED: line_rd_q <= line_mem[seed_q[IdxW-1:0]];
			ST_CUR:  line_rd_q <= line_mem[queue_rd_q];
			ST_SCAN: line_rd_q <= line_mem[k_q[IdxW-1:0]];
			default: ;
		endcase
		if (state_q == ST_SEED)
			queue_mem[0] <= seed_q[IdxW-1:0];
		else if (state_q == ST_CMP && !assigned_q[k_q[IdxW-1:0]] && nbr)
			queue_mem[tail_q[IdxW-1:0]] <= k_q[IdxW-1:0];
		if (state_q == ST_POP)
			queue_rd_q <= queue_mem[head_q[IdxW-1:0]];
	end

	always_comb begin
		next_seed = seed_q + CntW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			assigned_q  <= '0;
			count_q     <= '0;
			overflow_q  <= 1'b0;
			out_valid_q <= 1'b0;
			seed_q      <= '0;
			k_q         <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			rho_sum_q   <= '0;
			theta_sum_q <= '0;
			last_seed_q <= 1'b0;
		end else begin
			if (out_valid_q && cluster_out.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_LOAD: begin
					if (line_in.valid && line_in.ready) begin
						if (count_q != CntW'(MaxLines))
							count_q <= count_q + CntW'(1);
						else
							overflow_q <= 1'b1;
						if (line_in.data.last_line) begin
							seed_q  <= '0;
							state_q <= ST_SEED;
						end
					end
				end
				// find next unassigned seed; count_q >= 1 here
				ST_SEED: begin
					if (seed_q >= count_q || (count_q == CntW'(MaxLines) &&
					    seed_q == CntW'(MaxLines))) begin
						state_q    <= ST_LOAD;
						count_q    <= '0;
						overflow_q <= 1'b0;
						assigned_q <= '0;
					end else if (assigned_q[seed_q[IdxW-1:0]]) begin
						seed_q <= next_seed;
					end else begin
						assigned_q[seed_q[IdxW-1:0]] <= 1'b1;
						head_q      <= '0;
						tail_q      <= CntW'(1);
						rho_sum_q   <= '0;
						theta_sum_q <= '0;
						state_q     <= ST_POP;
					end
				end
				ST_POP: begin
					if (head_q == tail_q)
						state_q <= ST_DIV;
					else
						state_q <= ST_CUR;
				end
				ST_CUR: begin
					state_q <= ST_SCAN;
					k_q     <= '0;
				end
				ST_SCAN: begin
					// line_rd_q holds the popped line on first entry
					if (k_q == '0) begin
						cur_rho_q   <= $signed(line_rd_q[31:16]);
						cur_theta_q <= line_rd_q[15:0];
						rho_sum_q   <= rho_sum_q + SumW'($signed(line_rd_q[31:16]));
						theta_sum_q <= theta_sum_q + SumW'(line_rd_q[15:0]);
					end
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (!assigned_q[k_q[IdxW-1:0]] && nbr) begin
						assigned_q[k_q[IdxW-1:0]] <= 1'b1;
						tail_q <= tail_q + CntW'(1);
					end
					if (k_q + CntW'(1) >= count_q) begin
						head_q  <= head_q + CntW'(1);
						state_q <= ST_POP;
					end else begin
						k_q     <= k_q + CntW'(1);
						state_q <= ST_SCAN;
					end
				end
				ST_DIV: begin
					// last cluster when no unassigned line remains above seed
					last_seed_q <= !any_open;
					state_q     <= ST_WAIT;
				end
				ST_WAIT: begin
					if (div_done)
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q) begin
						out_q.mean_rho      <= div_rho;
						out_q.mean_theta    <= div_theta;
						out_q.member_count  <= 7'(tail_q);
						out_q.lines_dropped <= overflow_q;
						out_q.last_cluster  <= last_seed_q;
						out_valid_q         <= 1'b1;
						seed_q              <= next_seed;
						state_q             <= ST_SEED;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	hlcm_mean_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (div_req),
		.done       (div_done),
		.mean_rho   (div_rho),
		.mean_theta (div_theta)
	);
endmodule

// ----- verif/hlcm_cluster_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlcm_cluster_checker
// watches the line and cluster channels and the register port, predicts the
// cluster items of every set and compares them field by field in order
// ----------------------------------------------------------------------------
module hlcm_cluster_checker import hlcm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	hlcm_line_if        line_mon,
	hlcm_cluster_if     cluster_mon,
	output int          fail_count,
	output int          outstanding
);
	logic [14:0]        rho_window;
	logic [15:0]        theta_window;
	logic signed [15:0] kept_rho [MaxLines];
	logic [15:0]        kept_theta [MaxLines];
	int                 kept_n;
	bit                 overflowed;
	cluster_item_t      expected_clusters [$];
	int                 mismatches;

	assign outstanding = expected_clusters.size();

	function automatic bit close_lines(int a, int b);
		int dr;
		int dt;
		dr = int'(kept_rho[a]) - int'(kept_rho[b]);
		dt = int'(kept_theta[a]) - int'(kept_theta[b]);
		if (dr < 0) dr = -dr;
		if (dt < 0) dt = -dt;
		return dr <= int'(rho_window) && dt <= int'(theta_window);
	endfunction

	// breadth-first grouping, seeds in index order
	function automatic void predict_clusters();
		bit            taken [MaxLines];
		int            fifo [MaxLines];
		int            head;
		int            tail;
		int            cur;
		int            rsum;
		int            tsum;
		int            num;
		int            den;
		int            mr;
		cluster_item_t c;
		for (int i = 0; i < MaxLines; i++) taken[i] = 0;
		for (int seed = 0; seed < kept_n; seed++) begin
			if (taken[seed]) continue;
			taken[seed] = 1;
			head = 0;
			tail = 1;
			fifo[0] = seed;
			rsum = 0;
			tsum = 0;
			while (head < tail) begin
				cur = fifo[head];
				head++;
				rsum += int'(kept_rho[cur]);
				tsum += int'(kept_theta[cur]);
				for (int k = 0; k < kept_n; k++) begin
					if (!taken[k] && close_lines(cur, k)) begin
						taken[k] = 1;
						fifo[tail] = k;
						tail++;
					end
				end
			end
			num = 2 * rsum + tail;
			den = 2 * tail;
			if (num >= 0) mr = num / den;
			else mr = -((-num + den - 1) / den);
			c.mean_rho      = 16'(mr);
			c.mean_theta    = 16'((2 * tsum + tail) / den);
			c.member_count  = 7'(tail);
			c.lines_dropped = overflowed;
			c.last_cluster  = 1'b0;
			expected_clusters.insert(expected_clusters.size(), c);
		end
		if (expected_clusters.size() > 0)
			expected_clusters[expected_clusters.size() - 1].last_cluster = 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cluster_item_t got;
		cluster_item_t want;
		if (!arst_n) begin
			rho_window   <= 15'd80;
			theta_window <= 16'd2048;
			kept_n       = 0;
			overflowed   = 0;
			fail_count   <= 0;
			mismatches   = 0;
			expected_clusters.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == RegRhoBracket[0:0]) rho_window <= cfg_wdata[14:0];
				else theta_window <= cfg_wdata;
			end
			if (line_mon.valid && line_mon.ready) begin
				if (kept_n < MaxLines) begin
					kept_rho[kept_n]   = line_mon.data.line_rho;
					kept_theta[kept_n] = line_mon.data.line_theta;
					kept_n++;
				end else begin
					overflowed = 1;
				end
				if (line_mon.data.last_line) begin
					predict_clusters();
					kept_n = 0;
					overflowed = 0;
				end
			end
			if (cluster_mon.valid && cluster_mon.ready) begin
				got = cluster_mon.data;
				if (expected_clusters.size() == 0) begin
					fail_count <= fail_count + 1;
					if (mismatches < 10)
						$display("cluster item with nothing expected: rho %0d theta %0d count %0d",
							got.mean_rho, got.mean_theta, got.member_count);
					mismatches++;
				end else begin
					want = expected_clusters.pop_front();
					if (got !== want) begin
						fail_count <= fail_count + 1;
						if (mismatches < 10)
							$display({"cluster mismatch: expected rho %0d theta %0d count %0d ",
								"drop %0b last %0b, got rho %0d theta %0d count %0d drop %0b last %0b"},
								want.mean_rho, want.mean_theta, want.member_count,
								want.lines_dropped, want.last_cluster, got.mean_rho,
								got.mean_theta, got.member_count, got.lines_dropped,
								got.last_cluster);
						mismatches++;
					end
				end
			end
		end
	end
endmodule

// ----- verif/hough_line_cluster_merge_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hough_line_cluster_merge_core_tb
// drives line sets with directed corner cases and random clustered content
// through three idling phases and several bracket settings; the checker
// beside the block predicts every cluster item
// ----------------------------------------------------------------------------
module hough_line_cluster_merge_core_tb;
	import hlcm_pkg::*;

	localparam int StallLimit = 40000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [15:0] cfg_wdata;
	int          fail_count;
	int          outstanding;
	int          tx_idle_pct;
	int          rx_idle_pct;
	int          quiet_cycles;
	int          items_sent;
	logic [14:0] rho_win;
	logic [15:0] theta_win;

	hlcm_line_if    line_ch ();
	hlcm_cluster_if cluster_ch ();

	hough_line_cluster_merge_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.line_in     (line_ch),
		.cluster_out (cluster_ch)
	);

	hlcm_cluster_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.line_mon    (line_ch),
		.cluster_mon (cluster_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// receiver stalls at random, rate set per phase
	always @(posedge clk) begin
		cluster_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// watchdog: cycles in which no item moves on either channel
	always @(posedge clk) begin
		if ((line_ch.valid && line_ch.ready) || (cluster_ch.valid && cluster_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= StallLimit) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// one line item, with a random gap in front of it when the sender idles
	task automatic send_line(input logic [15:0] rho, input logic [15:0] theta,
			input logic last);
		if ($urandom_range(99) < tx_idle_pct) begin
			line_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		line_ch.valid <= 1'b1;
		line_ch.data  <= '{line_rho: rho, line_theta: theta, last_line: last};
		do @(posedge clk); while (!line_ch.ready);
		items_sent++;
	endtask

	// hold the sender until every cluster item is back, then let the block settle
	task automatic drain();
		line_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx[0:0];
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
		if (idx == RegRhoBracket) rho_win = value[14:0];
		else theta_win = value;
	endtask

	// a set of lines drawn round a few centres, so that clusters form;
	// noise sets use the full field ranges
	task automatic send_random_set(input int count, input bit noise);
		logic [15:0] centre_rho [4];
		logic [15:0] centre_theta [4];
		int          pick;
		int          spread_r;
		int          spread_t;
		logic [15:0] r;
		logic [15:0] t;
		spread_r = (int'(rho_win) > 2000) ? 2000 : int'(rho_win);
		spread_t = (int'(theta_win) > 4000) ? 4000 : int'(theta_win);
		for (int i = 0; i < 4; i++) begin
			centre_rho[i]   = 16'($urandom);
			centre_theta[i] = 16'($urandom);
		end
		for (int i = 0; i < count; i++) begin
			if (noise) begin
				r = 16'($urandom);
				t = 16'($urandom);
			end else begin
				pick = $urandom_range(3);
				r = centre_rho[pick] + 16'($urandom_range(2 * spread_r)) - 16'(spread_r);
				t = centre_theta[pick] + 16'($urandom_range(2 * spread_t)) - 16'(spread_t);
			end
			send_line(r, t, i == count - 1);
		end
	endtask

	task automatic random_phase(input int target);
		int size;
		while (items_sent < target) begin
			// mostly small sets, now and then a near-full, full or overfull one
			case ($urandom_range(19))
				0: size = $urandom_range(60, 67);
				1, 2: size = $urandom_range(9, 20);
				default: size = $urandom_range(1, 8);
			endcase
			send_random_set(size, $urandom_range(4) == 0);
		end
	endtask

	initial begin
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = '0;
		cfg_wdata        = '0;
		line_ch.valid    = 1'b0;
		line_ch.data     = '0;
		cluster_ch.ready = 1'b0;
		quiet_cycles     = 0;
		items_sent       = 0;
		rho_win          = 15'd80;
		theta_win        = 16'd2048;
		tx_idle_pct      = 38;
		rx_idle_pct      = 75;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: single line sets at the field extremes, under reset brackets
		send_line(16'h8000, 16'h0000, 1'b1);
		send_line(16'h7fff, 16'hffff, 1'b1);
		// pair exactly at both brackets, then one step beyond in rho
		send_line(16'd100, 16'd1000, 1'b0);
		send_line(16'd180, 16'd3048, 1'b1);
		send_line(16'd100, 16'd1000, 1'b0);
		send_line(16'd181, 16'd1000, 1'b1);
		// chain joined only transitively, seed taken from the lowest index
		send_line(16'd0, 16'd500, 1'b0);
		send_line(16'd5000, 16'd500, 1'b0);
		send_line(16'd160, 16'd500, 1'b0);
		send_line(16'd80, 16'd500, 1'b1);
		// mean of -1 and 0 is a half, rounds up; theta half likewise
		send_line(16'hffff, 16'd0, 1'b0);
		send_line(16'h0000, 16'd1, 1'b1);
		drain();

		// zero brackets: only identical lines merge
		write_reg(RegRhoBracket, 16'd0);
		write_reg(RegThetaBracket, 16'd0);
		send_line(16'd7, 16'd9, 1'b0);
		send_line(16'd7, 16'd9, 1'b0);
		send_line(16'd7, 16'd10, 1'b1);
		drain();
		// widest brackets, rho write carries a top bit that is masked off
		write_reg(RegRhoBracket, 16'hffff);
		write_reg(RegThetaBracket, 16'hffff);
		send_line(16'h8000, 16'h0000, 1'b0);
		send_line(16'h7fff, 16'hffff, 1'b0);
		send_line(16'h0000, 16'h8000, 1'b1);
		drain();
		write_reg(RegRhoBracket, 16'd80);
		write_reg(RegThetaBracket, 16'd2048);
		random_phase(90);
		drain();

		tx_idle_pct = 75;
		rx_idle_pct = 38;
		write_reg(RegRhoBracket, 16'($urandom_range(1, 4000)));
		write_reg(RegThetaBracket, 16'($urandom_range(1, 20000)));
		random_phase(170);
		drain();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_reg(RegRhoBracket, 16'd32767);
		write_reg(RegThetaBracket, 16'($urandom_range(100, 65535)));
		// overfull set whose closing line is itself dropped
		for (int i = 0; i < 66; i++)
			send_line(16'($urandom), 16'($urandom), i == 65);
		drain();
		write_reg(RegRhoBracket, 16'($urandom_range(20, 600)));
		write_reg(RegThetaBracket, 16'($urandom_range(100, 3000)));
		random_phase(300);

		line_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

// ----- hough_line_cluster_merge_core.f -----
rtl/hlcm_pkg.sv
rtl/hlcm_if.sv
rtl/hlcm_mean_div.sv
rtl/hough_line_cluster_merge_core.sv
verif/hlcm_cluster_checker.sv
verif/hough_line_cluster_merge_core_tb.sv
